/* src/pfe_pkg.sv */
package pfe_pkg;

   // Width of one stack value: signed fixed point, Q31.16 at the default fraction size.
   localparam int VALUE_WIDTH  = 48;
   localparam int OP_WIDTH     = 3;
   localparam int STATUS_WIDTH = 3;

   // Token operation codes.
   localparam logic [OP_WIDTH-1:0] OP_PUSH    = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_ADD     = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_SUB     = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_MUL     = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_DIV     = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_FINISH  = 3'd5;
   localparam logic [OP_WIDTH-1:0] OP_UNKNOWN = 3'd6;

   // Status codes.
   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_UNDER   = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DIVZERO = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_UNKNOWN = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_OVER    = 3'd4;

   // Saturation limits.
   localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic                   start;
      alu_op_type             op;
      logic [VALUE_WIDTH-1:0] left;
      logic [VALUE_WIDTH-1:0] right;
   } alu_req_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] value;
   } alu_rsp_type;

endpackage

/* src/pfe_req_if.sv */
interface pfe_req_if;
   import pfe_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_WIDTH-1:0]          operation;
   logic signed [VALUE_WIDTH-1:0] operand_value;

   modport source (output valid, output operation, output operand_value, input ready);
   modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

/* src/pfe_rsp_if.sv */
// DEPTH_WIDTH must equal $clog2(STACK_DEPTH + 1) of the block it connects to.
interface pfe_rsp_if #(
   parameter int DEPTH_WIDTH = 7
);
   import pfe_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] result_value;
   logic [STATUS_WIDTH-1:0]       status;
   logic [DEPTH_WIDTH-1:0]        stack_depth;
   logic                          final_res;

   modport source (output valid, output result_value, output status, output stack_depth,
                   output final_res, input ready);
   modport sink   (input valid, input result_value, input status, input stack_depth,
                   input final_res, output ready);
endinterface

/* src/pfe_stack_mem.sv */
module pfe_stack_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/pfe_alu.sv */
module pfe_alu #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfe_pkg::alu_req_type alu_req,
   output pfe_pkg::alu_rsp_type alu_rsp
);
   import pfe_pkg::*;

   localparam int MW = VALUE_WIDTH;
   localparam int DW = MW + FRACTION_BITS;
   localparam int AW = MW + 2;
   localparam int PW = 2 * MW;
   localparam int SW = $clog2(DW + 1);

   localparam logic [1:0] A_IDLE = 2'd0;
   localparam logic [1:0] A_RUN  = 2'd1;
   localparam logic [1:0] A_FIN  = 2'd2;

   logic [1:0]    state_ff, state_in;
   alu_op_type    op_ff, op_in;
   logic          neg_ff, neg_in;
   logic [SW-1:0] step_ff, step_in;
   logic [MW-1:0] acc_ff, acc_in;
   logic [DW-1:0] mq_ff, mq_in;
   logic [MW-1:0] opnd_ff, opnd_in;

   logic [MW-1:0] left_mag, right_mag;
   logic [AW-1:0] add_a, add_b, add_sum;
   logic          add_cin;
   logic          sum_fits;
   logic [MW-1:0] clamped;
   logic [PW-1:0] product, mag_full, bound;
   logic [MW-1:0] sat_value;

   assign left_mag  = alu_req.left[MW-1]  ? (~alu_req.left + MW'(1))  : alu_req.left;
   assign right_mag = alu_req.right[MW-1] ? (~alu_req.right + MW'(1)) : alu_req.right;

   // The one adder shared by every operation.
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      unique case (op_ff)
         ALU_ADD: begin
            add_a = {{2{acc_ff[MW-1]}}, acc_ff};
            add_b = {{2{opnd_ff[MW-1]}}, opnd_ff};
         end
         ALU_SUB: begin
            add_a   = {{2{acc_ff[MW-1]}}, acc_ff};
            add_b   = ~{{2{opnd_ff[MW-1]}}, opnd_ff};
            add_cin = 1'b1;
         end
         ALU_MUL: begin
            add_a = {2'b00, acc_ff};
            add_b = mq_ff[0] ? {2'b00, opnd_ff} : '0;
         end
         ALU_DIV: begin
            add_a   = {1'b0, acc_ff, mq_ff[DW-1]};
            add_b   = ~{2'b00, opnd_ff};
            add_cin = 1'b1;
         end
      endcase
      add_sum = add_a + add_b + AW'(add_cin);
   end

   assign sum_fits = (&add_sum[AW-1:MW-1]) | ~(|add_sum[AW-1:MW-1]);
   assign clamped  = sum_fits ? add_sum[MW-1:0] : (add_sum[AW-1] ? VAL_MIN : VAL_MAX);

   // Scale, saturate and sign the magnitude of a product or quotient.
   assign product  = {acc_ff, mq_ff[MW-1:0]};
   assign mag_full = (op_ff == ALU_MUL) ? (product >> FRACTION_BITS) : PW'(mq_ff);
   assign bound    = neg_ff ? PW'(VAL_MIN) : PW'(VAL_MAX);

   always_comb begin
      if (mag_full > bound) begin
         sat_value = neg_ff ? VAL_MIN : VAL_MAX;
      end else begin
         sat_value = neg_ff ? (~mag_full[MW-1:0] + MW'(1)) : mag_full[MW-1:0];
      end
   end

   assign alu_rsp.done  = (state_ff == A_FIN);
   assign alu_rsp.value = (op_ff == ALU_ADD || op_ff == ALU_SUB) ? acc_ff : sat_value;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      mq_in    = mq_ff;
      opnd_in  = opnd_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               op_in    = alu_req.op;
               neg_in   = alu_req.left[MW-1] ^ alu_req.right[MW-1];
               state_in = A_RUN;
               unique case (alu_req.op)
                  ALU_ADD, ALU_SUB: begin
                     acc_in  = alu_req.left;
                     opnd_in = alu_req.right;
                     step_in = SW'(1);
                  end
                  ALU_MUL: begin
                     acc_in  = '0;
                     opnd_in = left_mag;
                     mq_in   = DW'(right_mag);
                     step_in = SW'(MW);
                  end
                  ALU_DIV: begin
                     acc_in  = '0;
                     opnd_in = right_mag;
                     mq_in   = DW'(left_mag) << FRACTION_BITS;
                     step_in = SW'(DW);
                  end
               endcase
            end
         end
         A_RUN: begin
            unique case (op_ff)
               ALU_ADD, ALU_SUB: begin
                  acc_in = clamped;
               end
               ALU_MUL: begin
                  // Shift-add: one multiplier bit per cycle, product grows from the top.
                  acc_in          = add_sum[MW:1];
                  mq_in[MW-1:0]   = {add_sum[0], mq_ff[MW-1:1]};
               end
               ALU_DIV: begin
                  // Restoring division: one quotient bit per cycle.
                  if (!add_sum[AW-1]) begin
                     acc_in = add_sum[MW-1:0];
                     mq_in  = {mq_ff[DW-2:0], 1'b1};
                  end else begin
                     acc_in = {acc_ff[MW-2:0], mq_ff[DW-1]};
                     mq_in  = {mq_ff[DW-2:0], 1'b0};
                  end
               end
            endcase
            step_in = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      mq_ff   <= mq_in;
      opnd_ff <= opnd_in;
   end

endmodule

/* src/postfix_expression_evaluator_top.sv */
// Words are handled one at a time: ready is high only in S_IDLE, so a new word is accepted
// only after the result word of the last one is loaded. With a ready sink the next word is
// accepted in the same cycle as the result word is presented. The shared adder does one
// multiplier bit or one quotient bit per cycle, so divide is the slowest token.
// Reset is synchronous and active high; it empties the stack and clears the latched error.
module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH   = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   pfe_req_if.sink   req_chan,
   pfe_rsp_if.source rsp_chan
);
   import pfe_pkg::*;

   // Stack count width (holds STACK_DEPTH itself) and memory address width.
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int MAW = $clog2(STACK_DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_OPER  = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_REPLY = 3'd4;

   // The top of the stack lives in tos_ff; the memory holds the entries below it, so the
   // entry at depth n (counting from one) sits at address n - 1 once something is above it.
   // The stack memory itself is not cleared; there is no clearing pass after reset.
   logic [2:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [STATUS_WIDTH-1:0] err_ff, err_in;
   logic [VALUE_WIDTH-1:0]  tos_ff, tos_in;

   // The word under work.
   logic [OP_WIDTH-1:0]     op_ff, op_in;
   logic [VALUE_WIDTH-1:0]  val_ff, val_in;

   // What a finish word reports, captured before the stack and error are cleared.
   logic [STATUS_WIDTH-1:0] fin_status_ff, fin_status_in;
   logic [VALUE_WIDTH-1:0]  fin_value_ff, fin_value_in;

   // Output register: holds a finished result word while the sink stalls.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]           rsp_depth_ff, rsp_depth_in;
   logic                    rsp_final_ff, rsp_final_in;

   logic                    mem_we;
   logic [MAW-1:0]          mem_waddr, mem_raddr;
   logic [VALUE_WIDTH-1:0]  mem_rd_data;

   alu_req_type             alu_req;
   alu_rsp_type             alu_rsp;

   logic                    rsp_load;

   pfe_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (tos_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rd_data)
   );

   pfe_alu #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_chan.ready = (state_ff == S_IDLE);

   // A push moves the old top into the memory at count - 1; a binary operator reads the left
   // operand from count - 2. The read is registered, so the address is presented in S_EXEC and
   // the data is used in S_OPER.
   assign mem_waddr = MAW'(count_ff - CW'(1));
   assign mem_raddr = MAW'(count_ff - CW'(2));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      fin_status_in = fin_status_ff;
      fin_value_in  = fin_value_ff;
      mem_we        = 1'b0;
      rsp_load      = 1'b0;
      alu_req.start = 1'b0;
      alu_req.op    = ALU_ADD;
      alu_req.left  = mem_rd_data;
      alu_req.right = tos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.operation;
               val_in   = req_chan.operand_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_REPLY;
            priority if (op_ff == OP_FINISH) begin
               // Finish reports the top, a latched error or underflow if empty, then restarts.
               fin_value_in = '0;
               if (err_ff != ST_OK) begin
                  fin_status_in = err_ff;
               end else if (count_ff == '0) begin
                  fin_status_in = ST_UNDER;
               end else begin
                  fin_status_in = ST_OK;
                  fin_value_in  = tos_ff;
               end
               count_in = '0;
               err_in   = ST_OK;
            end else if (err_ff != ST_OK) begin
               // A latched error freezes the stack until the next finish.
            end else if (op_ff == OP_PUSH) begin
               if (count_ff == CW'(STACK_DEPTH)) begin
                  err_in = ST_OVER;
               end else begin
                  mem_we   = (count_ff != '0);
                  tos_in   = val_ff;
                  count_in = count_ff + CW'(1);
               end
            end else if (count_ff < CW'(2)) begin
               err_in = ST_UNDER;
            end else begin
               state_in = S_OPER;
            end
         end
         S_OPER: begin
            state_in = S_REPLY;
            unique case (op_ff)
               OP_ADD: begin
                  alu_req.start = 1'b1;
                  alu_req.op    = ALU_ADD;
                  state_in      = S_WAIT;
               end
               OP_SUB: begin
                  alu_req.start = 1'b1;
                  alu_req.op    = ALU_SUB;
                  state_in      = S_WAIT;
               end
               OP_MUL: begin
                  alu_req.start = 1'b1;
                  alu_req.op    = ALU_MUL;
                  state_in      = S_WAIT;
               end
               OP_DIV: begin
                  if (tos_ff == '0) begin
                     err_in = ST_DIVZERO;
                  end else begin
                     alu_req.start = 1'b1;
                     alu_req.op    = ALU_DIV;
                     state_in      = S_WAIT;
                  end
               end
               default: begin
                  // The unknown symbol and the unused code both land here.
                  err_in = ST_UNKNOWN;
               end
            endcase
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               tos_in   = alu_rsp.value;
               count_in = count_ff - CW'(1);
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result word contents.
   always_comb begin
      if (op_ff == OP_FINISH) begin
         rsp_value_in  = fin_value_ff;
         rsp_status_in = fin_status_ff;
         rsp_depth_in  = '0;
         rsp_final_in  = 1'b1;
      end else begin
         rsp_value_in  = (count_ff != '0) ? tos_ff : '0;
         rsp_status_in = err_ff;
         rsp_depth_in  = count_ff;
         rsp_final_in  = 1'b0;
      end
   end

   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         tos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         tos_ff       <= tos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      fin_status_ff <= fin_status_in;
      fin_value_ff  <= fin_value_in;
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_depth_ff  <= rsp_depth_in;
         rsp_final_ff  <= rsp_final_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.stack_depth  = rsp_depth_ff;
   assign rsp_chan.final_res    = rsp_final_ff;

`ifndef ASSERT_OFF
   // The stack never holds more entries than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond stack depth");

   // The arithmetic unit only finishes while the sequencer is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> (state_ff == S_WAIT))
      else $error("arithmetic result with no operation pending");

   // With an error latched, tokens other than finish leave the stack alone.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && err_ff != ST_OK && op_ff != OP_FINISH)
         |=> ($stable(count_ff) && $stable(tos_ff)))
      else $error("stack changed while an error was latched");
`endif

endmodule

/* dv/testbench.sv */
module testbench;
   import pfe_pkg::*;

   // The block under test is built at its default sizes; the checker below mirrors them.
   localparam int STACK_DEPTH   = 64;
   localparam int FRAC_BITS     = 16;
   localparam int DEPTH_WIDTH   = $clog2(STACK_DEPTH + 1);

   // Operation code 7 has no name in the package. The block must treat it
   // like the unknown symbol.
   localparam logic [OP_WIDTH-1:0] OP_RESERVED = 3'd7;

   // One run has four phases of handshake pressure. The sender idles and the
   // receiver stalls with these percentages.
   localparam int unsigned IDLE_BY_PHASE  [4] = '{0, 49, 0, 25};
   localparam int unsigned STALL_BY_PHASE [4] = '{0, 0, 49, 25};
   localparam int unsigned WORDS_PER_PHASE    = 430;

   // The slowest token is a divide. Even if
   // all of the roughly 1750 tokens were divides under the heaviest stalls, a run
   // would stay well under a fifth of this limit.
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 80;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      value_type           value;
   } token_type;

   // These are the fields of one result word.
   typedef struct {
      value_type               result_value;
      logic [STATUS_WIDTH-1:0] status;
      logic [DEPTH_WIDTH-1:0]  stack_depth;
      logic                    final_res;
   } rpn_word_type;

   localparam logic [OP_WIDTH-1:0] ARITH_OPS [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
   localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;

   // This class predicts the block. It keeps its own stack and its own latched
   // error, and it holds the expected result words in order of arrival.
   class rpn_scoreboard;
      value_type               stack_mem [STACK_DEPTH];
      int unsigned             depth = 0;
      logic [STATUS_WIDTH-1:0] error_code = ST_OK;
      rpn_word_type            pending_results [$];
      int unsigned             mismatch_count = 0;
      int unsigned             word_count = 0;
      int unsigned             final_count = 0;
      int unsigned             max_depth = 0;
      int unsigned             final_status_count [8];

      function logic [VALUE_WIDTH-1:0] magnitude(value_type v);
         return v[VALUE_WIDTH-1] ? ~v + 1'b1 : v;
      endfunction

      // The sign is applied after the magnitude saturates, so that the most
      // negative value stays reachable.
      function value_type from_magnitude(bit negative, logic [127:0] m);
         if (negative) begin
            if (m > 128'h8000_0000_0000) return VAL_MIN;
            return ~m[VALUE_WIDTH-1:0] + 1'b1;
         end
         if (m > 128'h7FFF_FFFF_FFFF) return VAL_MAX;
         return m[VALUE_WIDTH-1:0];
      endfunction

      function value_type clamp_sum(longint s);
         if (s > SUM_MAX) return VAL_MAX;
         if (s < SUM_MIN) return VAL_MIN;
         return value_type'(s);
      endfunction

      // The product is formed on magnitudes, so the shift truncates toward zero.
      function value_type fx_product(value_type lhs, value_type rhs);
         logic [127:0] p;
         p = 128'(magnitude(lhs)) * 128'(magnitude(rhs));
         return from_magnitude(lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1], p >> FRAC_BITS);
      endfunction

      function value_type fx_quotient(value_type lhs, value_type rhs);
         logic [127:0] q;
         q = (128'(magnitude(lhs)) << FRAC_BITS) / 128'(magnitude(rhs));
         return from_magnitude(lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1], q);
      endfunction

      // This records one accepted token and queues the word it must produce.
      // It returns 1 unless the token is ignored because an error is latched.
      function bit note_token(logic [OP_WIDTH-1:0] op, value_type value);
         rpn_word_type w;
         value_type    lhs;
         value_type    rhs;
         value_type    outv;
         bit           effective;
         effective = (error_code == ST_OK) || (op == OP_FINISH);
         w.result_value = '0;
         w.final_res    = 1'b0;
         outv           = '0;
         if (op == OP_FINISH) begin
            if (error_code == ST_OK) begin
               if (depth == 0) error_code = ST_UNDER;
               else w.result_value = stack_mem[depth-1];
            end
            w.status      = error_code;
            w.stack_depth = '0;
            w.final_res   = 1'b1;
            final_status_count[error_code]++;
            final_count++;
            depth      = 0;
            error_code = ST_OK;
         end else begin
            if (error_code == ST_OK) begin
               if (op == OP_PUSH) begin
                  if (depth >= STACK_DEPTH) error_code = ST_OVER;
                  else begin
                     stack_mem[depth] = value;
                     depth++;
                  end
               end else if (depth < 2) begin
                  error_code = ST_UNDER;
               end else begin
                  rhs = stack_mem[depth-1];
                  lhs = stack_mem[depth-2];
                  case (op)
                     OP_ADD: outv = clamp_sum(longint'(lhs) + longint'(rhs));
                     OP_SUB: outv = clamp_sum(longint'(lhs) - longint'(rhs));
                     OP_MUL: outv = fx_product(lhs, rhs);
                     OP_DIV: begin
                        if (rhs == 0) error_code = ST_DIVZERO;
                        else outv = fx_quotient(lhs, rhs);
                     end
                     default: error_code = ST_UNKNOWN;
                  endcase
                  if (error_code == ST_OK) begin
                     depth--;
                     stack_mem[depth-1] = outv;
                  end
               end
            end
            if (depth > 0) w.result_value = stack_mem[depth-1];
            w.status      = error_code;
            w.stack_depth = depth[DEPTH_WIDTH-1:0];
            if (depth > max_depth) max_depth = depth;
         end
         pending_results.push_back(w);
         return effective;
      endfunction

      function void check_result(value_type v, logic [STATUS_WIDTH-1:0] st,
                                 logic [DEPTH_WIDTH-1:0] dp, logic fin);
         rpn_word_type w;
         word_count++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Result word %0d arrived with nothing expected: value %h status %0d",
                        word_count, v, st);
            return;
         end
         w = pending_results.pop_front();
         if (v !== w.result_value || st !== w.status || dp !== w.stack_depth ||
             fin !== w.final_res) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"Result word %0d differs: expected value %h status %0d depth %0d ",
                         "final %b, got value %h status %0d depth %0d final %b"},
                        word_count, w.result_value, w.status, w.stack_depth, w.final_res,
                        v, st, dp, fin);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned effective_count;
   int unsigned cycle_count;

   rpn_scoreboard tracker = new;

   pfe_req_if req_chan ();
   pfe_rsp_if #(.DEPTH_WIDTH(DEPTH_WIDTH)) rsp_chan ();

   postfix_expression_evaluator_top #(
      .STACK_DEPTH   (STACK_DEPTH),
      .FRACTION_BITS (FRAC_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // The directed tokens come first. They walk through every operation code,
   // the saturation limits of add, subtract and multiply, and these errors:
   // an operator or a finish on a short stack, a divide by zero, the unknown
   // symbol and code 7. They also show that tokens after an error are
   // ignored, and that a finish takes the top of a stack of two entries.
   token_type directed_tokens [28] = '{
      '{OP_FINISH,   48'h0},
      '{OP_ADD,      48'h0},
      '{OP_PUSH,     48'h7_0000},
      '{OP_FINISH,   48'h0},
      '{OP_PUSH,     VAL_MAX},
      '{OP_PUSH,     VAL_MAX},
      '{OP_ADD,      48'h0},
      '{OP_PUSH,     VAL_MIN},
      '{OP_SUB,      48'h0},
      '{OP_PUSH,     VAL_MIN},
      '{OP_MUL,      48'h0},
      '{OP_PUSH,     48'hFFFF_FFFE_8000},
      '{OP_DIV,      48'h0},
      '{OP_PUSH,     48'h0},
      '{OP_DIV,      48'h0},
      '{OP_MUL,      48'h0},
      '{OP_FINISH,   48'h0},
      '{OP_PUSH,     48'h3_0000},
      '{OP_PUSH,     48'hFFFF_FFFE_0000},
      '{OP_UNKNOWN,  48'h0},
      '{OP_FINISH,   48'h0},
      '{OP_PUSH,     48'hFFFF_FFFF_FFFF},
      '{OP_PUSH,     48'h1_0000},
      '{OP_RESERVED, 48'h0},
      '{OP_FINISH,   48'h0},
      '{OP_PUSH,     48'h1_0000},
      '{OP_PUSH,     48'h3_0000},
      '{OP_FINISH,   48'h0}
   };

   // Operand values mix the saturation limits, zero (so that divides fail
   // now and then), small whole numbers, small fractions, one least
   // significant bit either way, and values over the full width.
   function automatic value_type random_operand();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return value_type'(longint'(int'($urandom_range(16)) - 8) * 65536);
         4: return value_type'(longint'($signed(raw[20:0])));
         5: return raw[0] ? value_type'(1) : value_type'(-1);
         6: return value_type'(longint'($signed(raw[31:0])));
         default: return raw[VALUE_WIDTH-1:0];
      endcase
   endfunction

   // The sender drives at the rising edge. A word counts as accepted at the
   // first later edge that sees ready high. Valid gets only one assignment
   // per edge: it is lowered only when an idle cycle is chosen.
   task automatic send_token(input logic [OP_WIDTH-1:0] op, input value_type value);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= op;
      req_chan.operand_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (tracker.note_token(op, value)) effective_count++;
   endtask

   // This sends one expression. Most expressions are well formed, so that the
   // arithmetic runs on real stack contents. Some fill the stack to two below
   // its top, up to it, or one or two entries past it. The rest are broken, or
   // are random noise that leaves state behind for the next expression.
   task automatic run_expression();
      int unsigned kind;
      int unsigned operands;
      int unsigned pushed;
      int unsigned live;
      int unsigned keep;
      kind = $urandom_range(99);
      if (kind < 75) begin
         operands = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         // Sometimes extra entries are left on the stack, and the finish must
         // discard them.
         keep   = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : 1;
         pushed = 0;
         live   = 0;
         while (pushed < operands || live > keep) begin
            if (pushed < operands && (live < 2 || $urandom_range(1) == 1)) begin
               send_token(OP_PUSH, random_operand());
               pushed++;
               live++;
            end else begin
               send_token(ARITH_OPS[$urandom_range(3)], random_operand());
               live--;
            end
         end
         send_token(OP_FINISH, random_operand());
      end else if (kind < 78) begin
         repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2))
            send_token(OP_PUSH, random_operand());
         repeat ($urandom_range(3)) send_token(ARITH_OPS[$urandom_range(3)], random_operand());
         send_token(OP_FINISH, random_operand());
      end else if (kind < 92) begin
         repeat ($urandom_range(3)) send_token(OP_PUSH, random_operand());
         repeat ($urandom_range(1, 4)) send_token(3'($urandom_range(7)), random_operand());
         send_token(OP_FINISH, random_operand());
      end else begin
         repeat ($urandom_range(1, 6)) send_token(3'($urandom_range(7)), random_operand());
      end
   endtask

   // The receiver samples the result channel at each edge and then chooses
   // its ready for the next cycle. It never drives ready twice at one edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            tracker.check_result(rsp_chan.result_value, rsp_chan.status,
                                 rsp_chan.stack_depth, rsp_chan.final_res);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // This watchdog ends a run that hangs.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d result words outstanding",
               cycle_count, tracker.pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned target;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.operation     = OP_PUSH;
      req_chan.operand_value = '0;
      idle_pct               = 0;
      stall_pct              = 0;
      effective_count        = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs with no idling on either side.
      foreach (directed_tokens[i]) send_token(directed_tokens[i].op, directed_tokens[i].value);

      // The random part runs through each pressure phase in turn. Tokens
      // ignored after a latched error do not count toward a phase.
      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = IDLE_BY_PHASE[phase];
         stall_pct = STALL_BY_PHASE[phase];
         target    = effective_count + WORDS_PER_PHASE;
         while (effective_count < target) run_expression();
      end
      req_chan.valid <= 1'b0;

      // The run waits for every expected word to arrive, then keeps the clock
      // running through a drain period in which no stray word may appear.
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d result words from %0d evaluated tokens: %0d expressions ended, %0s",
               tracker.word_count, effective_count, tracker.final_count,
               "under four handshake pressure phases.");
      $display({"Finals by status: ok %0d, underflow %0d, divide by zero %0d, unknown %0d, ",
                "overflow %0d; deepest stack %0d; mismatches %0d."},
               tracker.final_status_count[ST_OK], tracker.final_status_count[ST_UNDER],
               tracker.final_status_count[ST_DIVZERO], tracker.final_status_count[ST_UNKNOWN],
               tracker.final_status_count[ST_OVER], tracker.max_depth,
               tracker.mismatch_count);
      if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
